@@ sv/rbpf_pkg.sv @@
`timescale 1ns / 1ps

package rbpf_pkg;

   localparam int DEPTH_DEF    = 256;
   localparam int MAX_SEQ_DEF  = 8;
   localparam int MAX_READ_DEF = 64;

   localparam int CNT_W  = 9;   // lengths, counts, capacity
   localparam int COPY_W = 7;   // copied_count
   localparam int REG_W  = 64;  // widest register
   localparam int IDX_W  = 3;   // register index
   localparam int SLEN_W = 4;   // sequence length

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_FIND  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_REJECTED = 2'd2,
      STAT_BAD_LEN  = 2'd3
   } status_type;

   typedef enum logic [IDX_W-1:0] {
      REG_CAPACITY   = 3'd0,
      REG_HDR_BYTES  = 3'd1,
      REG_HDR_LENGTH = 3'd2,
      REG_FTR_BYTES  = 3'd3,
      REG_FTR_LENGTH = 3'd4,
      REG_UNUSED5    = 3'd5,
      REG_UNUSED6    = 3'd6,
      REG_UNUSED7    = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_ISSUE,
      ST_RD_DATA,
      ST_HDR,
      ST_FTR,
      ST_FIND_DONE
   } state_type;

   typedef struct packed {
      logic clear;  // restart the window
      logic push;   // a stored byte arrives
   } match_ctl_type;

endpackage

@@ sv/rbpf_mem.sv @@
`timescale 1ns / 1ps

module rbpf_mem #(
   parameter int DEPTH = rbpf_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(rbpf_pkg::DEPTH_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rbpf_match.sv @@
`timescale 1ns / 1ps

// Sliding window over the last MAX_SEQ bytes of a scan pass.
module rbpf_match #(
   parameter int MAX_SEQ = rbpf_pkg::MAX_SEQ_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rbpf_pkg::match_ctl_type       ctl,
   input  logic [7:0]                    in_byte,
   input  logic [8*MAX_SEQ-1:0]          seq,
   input  logic [rbpf_pkg::SLEN_W-1:0]   len,
   output logic                          hit
);

   localparam int SW = rbpf_pkg::SLEN_W;

   logic [7:0]    win_ff [MAX_SEQ];
   logic [7:0]    win_in [MAX_SEQ];
   logic [SW-1:0] cnt_ff;
   logic [SW-1:0] cnt_in;
   logic          all_eq;

   always_comb begin
      logic [SW-1:0]        idx;
      logic [8*MAX_SEQ-1:0] shifted;
      logic [7:0]           cur;
      all_eq = 1'b1;
      for (int d = 0; d < MAX_SEQ; d++) begin
         idx     = len - SW'(1) - SW'(d);
         shifted = seq >> {idx, 3'b000};
         cur     = (d == 0) ? in_byte : win_ff[(d == 0) ? 0 : d - 1];
         if ((SW'(d) < len) && (cur != shifted[7:0])) begin
            all_eq = 1'b0;
         end
      end
   end

   assign hit = ctl.push && ({1'b0, cnt_ff} + (SW+1)'(1) >= {1'b0, len}) && all_eq;

   always_comb begin
      for (int k = 0; k < MAX_SEQ; k++) begin
         win_in[k] = win_ff[k];
      end
      cnt_in = cnt_ff;
      if (ctl.clear) begin
         cnt_in = '0;
      end else if (ctl.push) begin
         win_in[0] = in_byte;
         for (int k = 1; k < MAX_SEQ; k++) begin
            win_in[k] = win_ff[k-1];
         end
         if (cnt_ff < SW'(MAX_SEQ)) begin
            cnt_in = cnt_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_SEQ; k++) begin
         win_ff[k] <= win_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ sv/ring_buffer_packet_finder.sv @@
`timescale 1ns / 1ps

// Byte ring buffer with all-or-nothing write bursts, bounded reads and a
// header/footer packet search.
// Request channel (req_*): one beat per item. mode 0 stores data_byte (the
// first byte of a burst carries the burst length in length), mode 1 reads up
// to length bytes (at most MAX_READ), mode 2 searches for a packet, mode 3 is
// dropped without a result.
// Response channel (rsp_*): one beat per write or find item, one beat per
// delivered byte for a read, last set on the final beat of the item.
// A write or a rejected read gives its beat the cycle after accept.
// Each delivered byte of a read is one access on the single read port of
// the byte store. A find walks the stored bytes once for the header and
// once from the header on for the footer, one byte a cycle. req_stall
// stays high while an item is in progress.
// Reset clears pointers, counters and burst state and loads capacity 256,
// other registers 0; the byte store itself is not cleared. Writing the
// capacity register empties the buffer. While rsp_stall is high with a beat
// pending, that beat holds and no further beat or request is taken.
module ring_buffer_packet_finder #(
   parameter int DEPTH    = rbpf_pkg::DEPTH_DEF,
   parameter int MAX_SEQ  = rbpf_pkg::MAX_SEQ_DEF,
   parameter int MAX_READ = rbpf_pkg::MAX_READ_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [7:0]                    req_data_byte,
   input  logic [rbpf_pkg::CNT_W-1:0]    req_length,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [7:0]                    rsp_read_byte,
   output logic                          rsp_last,
   output logic [rbpf_pkg::COPY_W-1:0]   rsp_copied_count,
   output logic [rbpf_pkg::CNT_W-1:0]    rsp_skip_length,
   output logic [rbpf_pkg::CNT_W-1:0]    rsp_packet_length,
   // register write port
   input  logic                          csr_write,
   input  logic [rbpf_pkg::IDX_W-1:0]    csr_index,
   input  logic [rbpf_pkg::REG_W-1:0]    csr_data
);

   localparam int CW        = rbpf_pkg::CNT_W;
   localparam int RW        = rbpf_pkg::COPY_W;
   localparam int SW        = rbpf_pkg::SLEN_W;
   // capacity is 9 bits wide, so no more than 511 entries are ever used
   localparam int MEM_DEPTH = (DEPTH < 511) ? DEPTH : 511;
   localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p,
                                             input logic [CW-1:0] cap);
      logic [CW:0] nx;
      nx = (CW+1)'(p) + (CW+1)'(1);
      ptr_inc = (nx == {1'b0, cap}) ? '0 : AW'(nx);
   endfunction

   // registers
   logic [CW-1:0]          cap_ff;
   logic [63:0]            hdr_bytes_ff, ftr_bytes_ff;
   logic [SW-1:0]          hdr_len_ff, ftr_len_ff;

   // buffer state
   logic [AW-1:0]          rp_ff, rp_in, wp_ff, wp_in;
   logic [CW-1:0]          used_ff, used_in;
   logic [CW-1:0]          burst_left_ff, burst_left_in;
   logic                   burst_rej_ff, burst_rej_in;

   rbpf_pkg::state_type    state_ff, state_in;

   // read and scan sequencing
   logic [RW-1:0]          rd_left_ff, rd_left_in;
   logic [RW-1:0]          rd_total_ff, rd_total_in;
   logic [CW-1:0]          iss_pos_ff, iss_pos_in;
   logic [AW-1:0]          iss_addr_ff, iss_addr_in;
   logic                   dvld_ff, dvld_in;
   logic [CW-1:0]          pcnt_ff, pcnt_in;
   logic [AW-1:0]          st_addr_ff, st_addr_in;
   logic [CW-1:0]          skip_ff, skip_in;
   logic [CW-1:0]          pkt_ff, pkt_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [RW-1:0]          rsp_cc_ff, rsp_cc_in;
   logic [CW-1:0]          rsp_skip_ff, rsp_skip_in;
   logic [CW-1:0]          rsp_pkt_ff, rsp_pkt_in;

   // memory and matcher hookup
   logic                   mem_we, mem_re;
   logic [AW-1:0]          mem_waddr, mem_raddr;
   logic [7:0]             mem_rdata;
   rbpf_pkg::match_ctl_type mctl;
   logic [8*MAX_SEQ-1:0]   mseq;
   logic [SW-1:0]          mlen;
   logic                   mhit;

   logic [CW-1:0]          ecap;
   logic [SW-1:0]          hl, fl;
   logic                   out_free, accept;

   // effective capacity: 0 acts as 1, anything past the store acts as full size
   always_comb begin
      if (cap_ff == '0) begin
         ecap = CW'(1);
      end else if (cap_ff > CW'(MEM_DEPTH)) begin
         ecap = CW'(MEM_DEPTH);
      end else begin
         ecap = cap_ff;
      end
   end

   assign hl = (hdr_len_ff > SW'(MAX_SEQ)) ? SW'(MAX_SEQ) : hdr_len_ff;
   assign fl = (ftr_len_ff > SW'(MAX_SEQ)) ? SW'(MAX_SEQ) : ftr_len_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == rbpf_pkg::ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   assign mseq = (state_ff == rbpf_pkg::ST_FTR) ? ftr_bytes_ff[8*MAX_SEQ-1:0]
                                                : hdr_bytes_ff[8*MAX_SEQ-1:0];
   assign mlen = (state_ff == rbpf_pkg::ST_FTR) ? fl : hl;

   always_comb begin
      logic [CW-1:0] bl_eff;
      logic          rej;
      logic [CW-1:0] n;
      logic          issue;
      logic [CW-1:0] pcnt_new;
      logic [AW-1:0] st_next;
      logic          pass_end;

      state_in       = state_ff;
      rp_in          = rp_ff;
      wp_in          = wp_ff;
      used_in        = used_ff;
      burst_left_in  = burst_left_ff;
      burst_rej_in   = burst_rej_ff;
      rd_left_in     = rd_left_ff;
      rd_total_in    = rd_total_ff;
      iss_pos_in     = iss_pos_ff;
      iss_addr_in    = iss_addr_ff;
      dvld_in        = 1'b0;
      pcnt_in        = pcnt_ff;
      st_addr_in     = st_addr_ff;
      skip_in        = skip_ff;
      pkt_in         = pkt_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_cc_in      = rsp_cc_ff;
      rsp_skip_in    = rsp_skip_ff;
      rsp_pkt_in     = rsp_pkt_ff;

      mem_we         = 1'b0;
      mem_waddr      = wp_ff;
      mem_re         = 1'b0;
      mem_raddr      = rp_ff;
      mctl           = '0;

      bl_eff   = burst_left_ff;
      rej      = burst_rej_ff;
      n        = '0;
      issue    = 1'b0;
      pcnt_new = pcnt_ff + CW'(1);
      st_next  = st_addr_ff;
      pass_end = 1'b0;

      unique case (state_ff)
         rbpf_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_status_in = rbpf_pkg::STAT_OK;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_cc_in     = '0;
               rsp_skip_in   = '0;
               rsp_pkt_in    = '0;
               unique case (rbpf_pkg::mode_type'(req_mode))
                  rbpf_pkg::MODE_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if ((burst_left_ff == '0) && (req_length == '0)) begin
                        rsp_status_in = rbpf_pkg::STAT_BAD_LEN;
                     end else begin
                        if (burst_left_ff == '0) begin
                           // burst start: all or nothing
                           rej    = req_length > (ecap - used_ff);
                           bl_eff = req_length;
                        end
                        if (rej || (used_ff >= ecap)) begin
                           rsp_status_in = rbpf_pkg::STAT_REJECTED;
                        end else begin
                           mem_we  = 1'b1;
                           wp_in   = ptr_inc(wp_ff, ecap);
                           used_in = used_ff + CW'(1);
                        end
                        burst_left_in = bl_eff - CW'(1);
                        burst_rej_in  = (burst_left_in == '0) ? 1'b0 : rej;
                     end
                  end
                  rbpf_pkg::MODE_READ: begin
                     if (req_length == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rbpf_pkg::STAT_BAD_LEN;
                     end else if (used_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rbpf_pkg::STAT_EMPTY;
                     end else begin
                        n = (req_length < used_ff) ? req_length : used_ff;
                        if (n > CW'(MAX_READ)) begin
                           n = CW'(MAX_READ);
                        end
                        rd_left_in  = RW'(n);
                        rd_total_in = RW'(n);
                        state_in    = rbpf_pkg::ST_RD_ISSUE;
                     end
                  end
                  rbpf_pkg::MODE_FIND: begin
                     skip_in = '0;
                     pkt_in  = '0;
                     pcnt_in = '0;
                     mctl.clear = 1'b1;
                     iss_pos_in  = '0;
                     iss_addr_in = rp_ff;
                     st_addr_in  = rp_ff;
                     if (hl != '0) begin
                        state_in = rbpf_pkg::ST_HDR;
                     end else if (fl != '0) begin
                        state_in = rbpf_pkg::ST_FTR;
                     end else begin
                        state_in = rbpf_pkg::ST_FIND_DONE;
                     end
                  end
                  rbpf_pkg::MODE_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end

         rbpf_pkg::ST_RD_ISSUE: begin
            mem_re    = 1'b1;
            mem_raddr = rp_ff;
            rp_in     = ptr_inc(rp_ff, ecap);
            used_in   = used_ff - CW'(1);
            state_in  = rbpf_pkg::ST_RD_DATA;
         end

         rbpf_pkg::ST_RD_DATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rbpf_pkg::STAT_OK;
               rsp_byte_in   = mem_rdata;
               rsp_last_in   = (rd_left_ff == RW'(1));
               rsp_cc_in     = rd_total_ff;
               rsp_skip_in   = '0;
               rsp_pkt_in    = '0;
               rd_left_in    = rd_left_ff - RW'(1);
               state_in      = (rd_left_ff == RW'(1)) ? rbpf_pkg::ST_IDLE
                                                      : rbpf_pkg::ST_RD_ISSUE;
            end
         end

         rbpf_pkg::ST_HDR, rbpf_pkg::ST_FTR: begin
            // issue one stored byte a cycle, compare as it returns
            issue     = iss_pos_ff < used_ff;
            mem_re    = issue;
            mem_raddr = iss_addr_ff;
            if (issue) begin
               iss_pos_in  = iss_pos_ff + CW'(1);
               iss_addr_in = ptr_inc(iss_addr_ff, ecap);
            end
            dvld_in   = issue;
            mctl.push = dvld_ff;
            if (dvld_ff) begin
               pcnt_in = pcnt_new;
               if (pcnt_new > CW'(mlen)) begin
                  st_next = ptr_inc(st_addr_ff, ecap);
               end
               st_addr_in = st_next;
            end
            pass_end = !issue && !dvld_ff;

            if (state_ff == rbpf_pkg::ST_HDR) begin
               if (mhit || pass_end) begin
                  // header found: footer pass starts at the header; no header: from the oldest byte
                  skip_in     = mhit ? (pcnt_new - CW'(mlen)) : '0;
                  iss_pos_in  = skip_in;
                  iss_addr_in = mhit ? st_next : rp_ff;
                  pcnt_in     = '0;
                  dvld_in     = 1'b0;
                  mctl.clear  = 1'b1;
                  state_in    = (fl != '0) ? rbpf_pkg::ST_FTR : rbpf_pkg::ST_FIND_DONE;
               end
            end else begin
               if (mhit || pass_end) begin
                  pkt_in   = mhit ? pcnt_new : '0;
                  dvld_in  = 1'b0;
                  state_in = rbpf_pkg::ST_FIND_DONE;
               end
            end
         end

         rbpf_pkg::ST_FIND_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rbpf_pkg::STAT_OK;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_cc_in     = '0;
               rsp_skip_in   = skip_ff;
               rsp_pkt_in    = pkt_ff;
               state_in      = rbpf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rbpf_pkg::ST_IDLE;
         end
      endcase

      // capacity write empties the buffer (only while idle is for the user to keep; not enforced here)
      if (csr_write && (rbpf_pkg::reg_index_type'(csr_index) == rbpf_pkg::REG_CAPACITY)) begin
         rp_in         = '0;
         wp_in         = '0;
         used_in       = '0;
         burst_left_in = '0;
         burst_rej_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rbpf_pkg::ST_IDLE;
         rp_ff         <= '0;
         wp_ff         <= '0;
         used_ff       <= '0;
         burst_left_ff <= '0;
         burst_rej_ff  <= 1'b0;
         dvld_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         used_ff       <= used_in;
         burst_left_ff <= burst_left_in;
         burst_rej_ff  <= burst_rej_in;
         dvld_ff       <= dvld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_left_ff    <= rd_left_in;
      rd_total_ff   <= rd_total_in;
      iss_pos_ff    <= iss_pos_in;
      iss_addr_ff   <= iss_addr_in;
      pcnt_ff       <= pcnt_in;
      st_addr_ff    <= st_addr_in;
      skip_ff       <= skip_in;
      pkt_ff        <= pkt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_cc_ff     <= rsp_cc_in;
      rsp_skip_ff   <= rsp_skip_in;
      rsp_pkt_ff    <= rsp_pkt_in;
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CW'(256);
         hdr_bytes_ff <= '0;
         hdr_len_ff   <= '0;
         ftr_bytes_ff <= '0;
         ftr_len_ff   <= '0;
      end else if (csr_write) begin
         unique case (rbpf_pkg::reg_index_type'(csr_index))
            rbpf_pkg::REG_CAPACITY:   cap_ff       <= csr_data[CW-1:0];
            rbpf_pkg::REG_HDR_BYTES:  hdr_bytes_ff <= csr_data;
            rbpf_pkg::REG_HDR_LENGTH: hdr_len_ff   <= csr_data[SW-1:0];
            rbpf_pkg::REG_FTR_BYTES:  ftr_bytes_ff <= csr_data;
            rbpf_pkg::REG_FTR_LENGTH: ftr_len_ff   <= csr_data[SW-1:0];
            default: begin
            end
         endcase
      end
   end

   rbpf_mem #(
      .DEPTH (MEM_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_data_byte),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rbpf_match #(
      .MAX_SEQ (MAX_SEQ)
   ) u_match (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mctl),
      .in_byte (mem_rdata),
      .seq     (mseq),
      .len     (mlen),
      .hit     (mhit)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_byte     = rsp_byte_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_copied_count  = rsp_cc_ff;
   assign rsp_skip_length   = rsp_skip_ff;
   assign rsp_packet_length = rsp_pkt_ff;

endmodule
